### rtl/core/bfa_pkg.sv
// Package for the bitmap frame allocator core: sizes, command kinds and
// configuration register indexes. No dependencies.
package bfa_pkg;

  // Bitmap geometry
  localparam int MAX_FRAMES = 65536;
  localparam int PAGE_SHIFT = 12;
  localparam int BITS_W     = 32;                        // bitmap word width
  localparam int WORDS      = (MAX_FRAMES + BITS_W - 1) / BITS_W;
  localparam int WORD_W     = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Field and register widths
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 32;
  localparam int KIND_W     = 3;
  localparam int COUNT_W    = 17;
  localparam int LIMIT_W    = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Frame numbers: wide enough for a page number plus one and for the limit
  localparam int FN_W       = ADDR_W - PAGE_SHIFT + 1;
  localparam int CNT1_W     = $clog2(BITS_W + 1);      // bits changed in a word

  // Command kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC     = 3'd0,
    KIND_FREE      = 3'd1,
    KIND_RANGE_REL = 3'd2,
    KIND_RANGE_USE = 3'd3,
    KIND_ALL_USED  = 3'd4
  } kind_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd1;

endpackage

### rtl/core/bitmap_frame_allocator_core.sv
// Bitmap frame allocator core: used/free bitmap in a word memory, free count
// and a small sequencer around one word-wide mask/compare step. Uses bfa_pkg.
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   config   | cfg_we_i, cfg_index_i, cfg_wdata_i             | in
//   command  | in_valid_i/in_ready_o, kind_i, base_address_i, | in
//            | range_length_i                                 |
//   result   | out_valid_o/out_ready_i, frame_address_o,      | out
//            | granted_o, free_count_o                        |
//
// One command word at a time; the bitmap memory has one port and the walk
// goes one 32-bit bitmap word per step. Allocate: setup, clip, then read and
// check per word scanned (up to limit/32 words, rounded up). Free: setup,
// clip, read, check, count. Ranges: setup, clip, then read, check and count
// per word touched. Mark all used and the pass after reset rewrite all 2048
// bitmap words, one per cycle; no command is taken during the reset pass. A
// finished result sits in the output register while the next command is
// taken; a result waits only if the previous one is unread.
module bitmap_frame_allocator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bfa_pkg::KIND_W-1:0]        kind_i,
  input  logic [bfa_pkg::ADDR_W-1:0]        base_address_i,
  input  logic [bfa_pkg::LEN_W-1:0]         range_length_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bfa_pkg::ADDR_W-1:0]        frame_address_o,
  output logic                              granted_o,
  output logic [bfa_pkg::COUNT_W-1:0]       free_count_o
);
  import bfa_pkg::*;

  typedef enum logic [7:0] {
    ST_FILL  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_SETUP = 8'b0000_0100,
    ST_CLIP  = 8'b0000_1000,
    ST_READ  = 8'b0001_0000,
    ST_CHECK = 8'b0010_0000,
    ST_COUNT = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [BITS_W-1:0] ONES      = '1;
  localparam logic [4:0]        TOP_BIT   = 5'(BITS_W - 1);

  // Lowest set bit of a bitmap word
  function automatic logic [4:0] lowest_set(input logic [BITS_W-1:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int b = BITS_W - 1; b >= 0; b--) begin
      if (v[b]) idx = 5'(b);
    end
    return idx;
  endfunction

  state_e                state_q, state_d;
  kind_e                 kind_q, kind_d;
  logic [ADDR_W-1:0]     base_q, base_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [FN_W-1:0]       first_q, first_d;
  logic [FN_W-1:0]       stop_q, stop_d;      // exclusive end, then last frame
  logic [WORD_W-1:0]     w_q, w_d;
  logic [CNT1_W-1:0]     delta_q, delta_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [LIMIT_W-1:0]    limit_q;
  logic                  enable_q;
  logic [ADDR_W-1:0]     res_addr_q, res_addr_d;
  logic                  res_grant_q, res_grant_d;
  logic                  out_valid_q;
  logic [ADDR_W-1:0]     out_addr_q;
  logic                  out_grant_q;
  logic [COUNT_W-1:0]    out_count_q;
  logic                  load_out;

  // Bitmap memory, one port
  logic [BITS_W-1:0]     bitmap_mem [WORDS];
  logic [BITS_W-1:0]     rdata_q;
  logic                  mem_re, mem_we;
  logic [BITS_W-1:0]     mem_wdata;

  // Word walk helpers
  logic [FN_W-1:0]       lim_ext, lim_eff, stop_clip;
  logic [ADDR_W-1:0]     lo_rel, hi_rel, hi_use;
  logic [WORD_W-1:0]     first_w, last_w;
  logic [4:0]            lo_bit, hi_bit, pick;
  logic [BITS_W-1:0]     mask, cand;
  logic                  is_last;

  assign lim_ext   = FN_W'(limit_q);
  assign lim_eff   = (lim_ext > FN_W'(MAX_FRAMES)) ? FN_W'(MAX_FRAMES) : lim_ext;
  assign stop_clip = (stop_q > lim_eff) ? lim_eff : stop_q;

  // Page rounding: inward for release, outward for claim
  assign lo_rel = (base_q + PAGE_MASK) & ~PAGE_MASK;
  assign hi_rel = base_q + len_q;
  assign hi_use = base_q + len_q + PAGE_MASK;

  // Bit window of the current word
  assign first_w = first_q[WORD_W+4:5];
  assign last_w  = stop_q[WORD_W+4:5];
  assign is_last = (w_q == last_w);
  assign lo_bit  = (w_q == first_w) ? first_q[4:0] : 5'd0;
  assign hi_bit  = is_last ? stop_q[4:0] : TOP_BIT;
  assign mask    = (ONES << lo_bit) & (ONES >> (TOP_BIT - hi_bit));
  assign cand    = ~rdata_q & mask;
  assign pick    = lowest_set(cand);

  assign load_out = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    base_d      = base_q;
    len_d       = len_q;
    first_d     = first_q;
    stop_d      = stop_q;
    w_d         = w_q;
    delta_d     = delta_q;
    count_d     = count_q;
    res_addr_d  = res_addr_q;
    res_grant_d = res_grant_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_wdata   = rdata_q;
    unique case (state_q)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = ONES;
        if (kind_q == KIND_ALL_USED) count_d = '0;
        if (w_q == WORD_W'(WORDS - 1)) begin
          state_d = (kind_q == KIND_ALL_USED) ? ST_OUT : ST_IDLE;
        end else begin
          w_d = w_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d      = kind_e'(kind_i);
          base_d      = base_address_i;
          len_d       = range_length_i;
          res_addr_d  = '0;
          res_grant_d = 1'b0;
          state_d     = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = ST_CLIP;
        case (kind_q)
          KIND_ALLOC: begin
            first_d = '0;
            stop_d  = lim_eff;
            if (!enable_q) state_d = ST_OUT;
          end
          KIND_FREE: begin
            first_d = FN_W'(base_q[ADDR_W-1:PAGE_SHIFT]);
            stop_d  = FN_W'(base_q[ADDR_W-1:PAGE_SHIFT]) + 1'b1;
            if (!enable_q) state_d = ST_OUT;
          end
          KIND_RANGE_REL: begin
            first_d = FN_W'(lo_rel[ADDR_W-1:PAGE_SHIFT]);
            stop_d  = FN_W'(hi_rel[ADDR_W-1:PAGE_SHIFT]);
          end
          KIND_RANGE_USE: begin
            first_d = FN_W'(base_q[ADDR_W-1:PAGE_SHIFT]);
            stop_d  = FN_W'(hi_use[ADDR_W-1:PAGE_SHIFT]);
          end
          KIND_ALL_USED: begin
            w_d     = '0;
            state_d = ST_FILL;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_CLIP: begin
        // empty after clipping to the limit: nothing to do
        if (first_q >= stop_clip) begin
          state_d = ST_OUT;
        end else begin
          stop_d  = stop_clip - 1'b1;    // from here on: last frame, inclusive
          w_d     = first_q[WORD_W+4:5];
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (kind_q == KIND_ALLOC) begin
          if (cand != '0) begin
            mem_we      = 1'b1;
            mem_wdata   = rdata_q | (BITS_W'(1) << pick);
            count_d     = count_q - 1'b1;
            res_addr_d  = ADDR_W'({w_q, pick}) << PAGE_SHIFT;
            res_grant_d = 1'b1;
            state_d     = ST_OUT;
          end else if (is_last) begin
            state_d = ST_OUT;
          end else begin
            w_d     = w_q + 1'b1;
            state_d = ST_READ;
          end
        end else begin
          mem_we = 1'b1;
          if (kind_q == KIND_RANGE_USE) begin
            mem_wdata = rdata_q | mask;
            delta_d   = CNT1_W'($countones(~rdata_q & mask));
          end else begin
            mem_wdata = rdata_q & ~mask;
            delta_d   = CNT1_W'($countones(rdata_q & mask));
          end
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (kind_q == KIND_RANGE_USE) count_d = count_q - COUNT_W'(delta_q);
        else                          count_d = count_q + COUNT_W'(delta_q);
        if (is_last) begin
          state_d = ST_OUT;
        end else begin
          w_d     = w_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_OUT: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      kind_q      <= KIND_ALLOC;
      w_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      w_q     <= w_d;
      count_q <= count_d;
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= '0;
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LIMIT:  limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_ENABLE: enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Working payload
  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    len_q       <= len_d;
    first_q     <= first_d;
    stop_q      <= stop_d;
    delta_q     <= delta_d;
    res_addr_q  <= res_addr_d;
    res_grant_q <= res_grant_d;
    if (load_out) begin
      out_addr_q  <= res_addr_q;
      out_grant_q <= res_grant_q;
      out_count_q <= count_q;
    end
  end

  // Bitmap memory: registered read, same address for read and write
  always_ff @(posedge clk_i) begin
    if (mem_we) bitmap_mem[w_q] <= mem_wdata;
    if (mem_re) rdata_q <= bitmap_mem[w_q];
  end

  assign out_valid_o     = out_valid_q;
  assign frame_address_o = out_addr_q;
  assign granted_o       = out_grant_q;
  assign free_count_o    = out_count_q;

endmodule

### sim/frame_map_check_pkg.sv
// Scoreboard for the bitmap frame allocator bench: a bit-level copy of the
// frame map and free count, plus the queue of predicted result words.
// Depends on bfa_pkg.
package frame_map_check_pkg;
  import bfa_pkg::*;

  localparam logic [ADDR_W-1:0] PAGE_MASK = {{(ADDR_W-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};

  typedef struct packed {
    logic [ADDR_W-1:0]  frame_address;
    logic               granted;
    logic [COUNT_W-1:0] free_count;
  } alloc_result_t;

  class frame_map_scoreboard;
    bit [BITS_W-1:0]  used_map [WORDS];
    bit [COUNT_W-1:0] open_count;
    bit [LIMIT_W-1:0] frame_limit;
    bit               alloc_on;
    alloc_result_t    expected_q [$];
    int unsigned      mismatches;
    int unsigned      results_seen;

    // state after reset: every frame used, nothing free, registers zero
    function void clear();
      foreach (used_map[i]) used_map[i] = '1;
      open_count   = '0;
      frame_limit  = '0;
      alloc_on     = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      expected_q.delete();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_LIMIT:  frame_limit = value[LIMIT_W-1:0];
        CFG_ENABLE: alloc_on = value[0];
        default: ;
      endcase
    endfunction

    // frames the map covers; a limit past the array clamps to its size
    function int unsigned reach();
      return (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
    endfunction

    function bit frame_taken(int unsigned f);
      return used_map[f / BITS_W][f % BITS_W];
    endfunction

    function void set_frame(int unsigned f, bit taken);
      used_map[f / BITS_W][f % BITS_W] = taken;
    endfunction

    // frames [first, stop) clipped to the covered area
    function void walk_frames(int unsigned first, int unsigned stop, bit freeing);
      int unsigned f;
      if (stop > reach()) stop = reach();
      for (f = first; f < stop; f++) begin
        if (freeing && frame_taken(f)) begin
          set_frame(f, 1'b0);
          open_count++;
        end else if (!freeing && !frame_taken(f)) begin
          set_frame(f, 1'b1);
          open_count--;
        end
      end
    endfunction

    // predict the result word of one accepted command
    function void note_command(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] base,
                               logic [LEN_W-1:0] len);
      alloc_result_t r;
      logic [ADDR_W-1:0] lo, hi;
      int unsigned f;
      r = '0;
      case (kind)
        KIND_ALLOC: begin
          if (alloc_on) begin
            for (f = 0; f < reach(); f++) begin
              if (!frame_taken(f)) begin
                set_frame(f, 1'b1);
                open_count--;
                r.frame_address = f << PAGE_SHIFT;
                r.granted = 1'b1;
                break;
              end
            end
          end
        end
        KIND_FREE: begin
          if (alloc_on) begin
            f = base >> PAGE_SHIFT;
            if (f < reach() && frame_taken(f)) begin
              set_frame(f, 1'b0);
              open_count++;
            end
          end
        end
        KIND_RANGE_REL: begin
          // round inward, sums wrap at 32 bits
          lo = (base + PAGE_MASK) & ~PAGE_MASK;
          hi = (base + len) & ~PAGE_MASK;
          walk_frames(lo >> PAGE_SHIFT, hi >> PAGE_SHIFT, 1'b1);
        end
        KIND_RANGE_USE: begin
          // round outward
          lo = base & ~PAGE_MASK;
          hi = (base + len + PAGE_MASK) & ~PAGE_MASK;
          walk_frames(lo >> PAGE_SHIFT, hi >> PAGE_SHIFT, 1'b0);
        end
        KIND_ALL_USED: begin
          foreach (used_map[i]) used_map[i] = '1;
          open_count = '0;
        end
        default: ;
      endcase
      r.free_count = open_count;
      expected_q.push_back(r);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        flag($sformatf("word %0d with none expected: addr %h granted %b count %0d",
                       results_seen, got.frame_address, got.granted, got.free_count));
        return;
      end
      want = expected_q.pop_front();
      if (got.frame_address !== want.frame_address || got.granted !== want.granted ||
          got.free_count !== want.free_count)
        flag($sformatf({"word %0d: expected addr %h granted %b count %0d, ",
                        "got addr %h granted %b count %0d"}, results_seen,
                       want.frame_address, want.granted, want.free_count,
                       got.frame_address, got.granted, got.free_count));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

### sim/bitmap_frame_allocator_core_tb.sv
// Bench for bitmap_frame_allocator_core: directed and random command words
// with random stalls on both channels, checked against frame_map_check_pkg.
// Depends on bfa_pkg and frame_map_check_pkg.
module bitmap_frame_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;
  import frame_map_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 20_000_000;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES   = 100;

  // command codes the block does not define
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  // random phases: limit register, enable register, command count
  localparam int NUM_PHASES = 13;
  localparam int unsigned PHASE_LIMIT [NUM_PHASES] =
    '{0, 1, 31, 32, 33, 100, 700, 2000, 300, 65536, 131071, 64, 17};
  localparam bit PHASE_ENABLE [NUM_PHASES] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 1};
  localparam int unsigned PHASE_ITEMS [NUM_PHASES] =
    '{60, 80, 120, 120, 150, 200, 250, 200, 100, 40, 30, 200, 150};

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [KIND_W-1:0]     kind_i         = '0;
  logic [ADDR_W-1:0]     base_address_i = '0;
  logic [LEN_W-1:0]      range_length_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [ADDR_W-1:0]     frame_address_o;
  logic                  granted_o;
  logic [COUNT_W-1:0]    free_count_o;

  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;
  bit          rx_hold     = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned cmd_count   = 0;

  frame_map_scoreboard sb = new;

  bitmap_frame_allocator_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .base_address_i (base_address_i),
    .range_length_i (range_length_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_address_o(frame_address_o),
    .granted_o      (granted_o),
    .free_count_o   (free_count_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls after each word, long hold driven below
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result({frame_address_o, granted_o, free_count_o});
        if (sb.results_seen % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        stall_left = rx_calm ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= !rx_hold;
      end
    end
  end

  // one long receiver hold-off so the block backs up into the command port
  initial begin : result_hold
    while (sb.results_seen < 300) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // offer one command word, predict it once taken
  task automatic send_command(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] base,
                              input logic [LEN_W-1:0] len);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    base_address_i <= base;
    range_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(kind, base, len);
    cmd_count++;
  endtask

  // stop offering and wait until every predicted word came back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // write both registers on back-to-back cycles
  task automatic set_config(input int unsigned limit, input bit enable);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_LIMIT;
    cfg_wdata_i <= limit[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_index_i <= CFG_ENABLE;
    cfg_wdata_i <= {{(CFG_DATA_W-1){1'b0}}, enable};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(CFG_LIMIT, limit[CFG_DATA_W-1:0]);
    sb.write_reg(CFG_ENABLE, {{(CFG_DATA_W-1){1'b0}}, enable});
  endtask

  // mostly well-formed traffic around the covered frames, some raw noise
  task automatic random_command(input int unsigned reach);
    int unsigned pick, fr, off;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
    pick = $urandom_range(0, 99);
    base = $urandom;
    len  = $urandom;
    fr   = $urandom_range(0, 1) ? $urandom_range(0, reach + 3) : $urandom_range(0, 40);
    case ($urandom_range(0, 2))
      0:       off = 0;
      1:       off = PAGE_MASK;
      default: off = $urandom_range(0, PAGE_MASK);
    endcase
    if (pick < 38) begin
      kind = KIND_ALLOC;
    end else if (pick < 62) begin
      kind = KIND_FREE;
      if (pick < 58) base = (fr << PAGE_SHIFT) | off;
    end else if (pick < 92) begin
      kind = (pick < 77) ? KIND_RANGE_REL : KIND_RANGE_USE;
      // about one range in eight keeps raw 32-bit base and length
      if (pick % 8 != 0) begin
        base = (fr << PAGE_SHIFT) | off;
        if ($urandom_range(0, 7) == 0)
          len = $urandom_range(0, reach + 2) << PAGE_SHIFT;
        else
          len = ($urandom_range(0, 9) << PAGE_SHIFT) + $urandom_range(0, PAGE_MASK);
      end
    end else if (pick < 93) begin
      kind = KIND_ALL_USED;
    end else if (pick < 96) begin
      kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    end else begin
      kind = KIND_W'($urandom_range(KIND_ALLOC, KIND_SPARE_LAST));
    end
    send_command(kind, base, len);
  endtask

  initial begin : stimulus
    int k, p, i;
    int unsigned reach;
    sb.clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the clearing pass after reset keeps the command port closed
    do @(posedge clk_i); while (!in_ready_o);

    // disabled: allocate and free ignored, ranges still act
    set_config(40, 1'b0);
    send_command(KIND_ALLOC, '0, '0);
    send_command(KIND_RANGE_REL, 32'h0000_0000, 32'h0001_0000);
    send_command(KIND_FREE, 32'h0000_1000, '0);
    for (k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
      send_command(k[KIND_W-1:0], '1, '1);
    settle();

    set_config(40, 1'b1);
    send_command(KIND_ALLOC, '0, '0);                         // frame zero
    send_command(KIND_ALLOC, '1, '1);
    send_command(KIND_FREE, 32'h0000_1234, '0);
    send_command(KIND_FREE, 32'h0000_1000, '0);               // already free
    send_command(KIND_FREE, 32'h0003_0000, '0);               // past the limit
    send_command(KIND_FREE, 32'hFFFF_FFFF, '0);
    send_command(KIND_RANGE_USE, 32'h0000_1FFF, 32'h0000_0002); // rounds out to two frames
    send_command(KIND_RANGE_REL, 32'h0000_1001, 32'h0000_1FFF); // rounds in to one frame
    send_command(KIND_RANGE_REL, 32'h0000_5001, 32'h0000_0FFF); // empty after rounding
    send_command(KIND_RANGE_REL, 32'hFFFF_F000, 32'h0000_2000); // end wraps below start
    send_command(KIND_RANGE_USE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(KIND_RANGE_USE, 32'h0003_0000, 32'h0001_0000); // wholly past the limit
    send_command(KIND_RANGE_REL, 32'h0000_0000, 32'hFFFF_FFFF);
    send_command(KIND_ALL_USED, '0, '0);
    send_command(KIND_ALLOC, '0, '0);                         // nothing free
    send_command(KIND_RANGE_REL, '0, '0);
    settle();

    // zero limit: nothing is ever covered
    set_config(0, 1'b1);
    send_command(KIND_RANGE_REL, '0, '1);
    send_command(KIND_ALLOC, '0, '0);
    send_command(KIND_FREE, '0, '0);

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_config(PHASE_LIMIT[p], PHASE_ENABLE[p]);
      reach = (PHASE_LIMIT[p] > MAX_FRAMES) ? MAX_FRAMES : PHASE_LIMIT[p];
      // open the covered frames so allocations find room
      send_command(KIND_RANGE_REL, '0, reach << PAGE_SHIFT);
      for (i = 0; i < PHASE_ITEMS[p]; i++) begin
        if (cmd_count % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        if (cmd_count == 900) settle();
        random_command(reach);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/bfa_pkg.sv
rtl/core/bitmap_frame_allocator_core.sv
sim/frame_map_check_pkg.sv
sim/bitmap_frame_allocator_core_tb.sv
